### sv/mrbm_pkg.sv
// ----------------------------------------------------------------------------
// Maximal rectangle package
// Sizes, codes and types used by the maximal rectangle block.
// ----------------------------------------------------------------------------
package mrbm_pkg;

  localparam int MAX_COLS = 64;
  localparam int MAX_ROWS = 1024;

  localparam int CW      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int CNTW    = $clog2(MAX_COLS + 1);
  localparam int HW      = $clog2(MAX_ROWS + 1);
  localparam int PW      = HW + CNTW;
  localparam int AREA_W  = 17;
  localparam int CFG_W   = 7;
  localparam int IN_DW   = 8;
  localparam int OUT_DW  = ((2 * AREA_W + 7) / 8) * 8;

  localparam logic [AREA_W-1:0] AREA_MAX     = '1;
  localparam logic [CFG_W-1:0]  NUM_COLS_RST = CFG_W'(MAX_COLS);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_HGT   = 5'b00010,
    ST_RDTOP = 5'b00100,
    ST_TOP   = 5'b01000,
    ST_FIN   = 5'b10000
  } state_e;

  typedef struct packed {
    logic [CW-1:0] idx;
    logic [CW-1:0] left;
    logic [HW-1:0] hgt;
  } stk_entry_t;

endpackage

### sv/maximal_rectangle_binary_matrix.sv
// ----------------------------------------------------------------------------
// Maximal rectangle in a binary matrix
// Histogram-and-stack search for the largest all-ones rectangle.
// ----------------------------------------------------------------------------
// Cells arrive on the s_axis channel in row-major order, one request per
// cell: tdata bit 0 is the cell value and tlast marks the final cell of the
// matrix. The cfg channel sets the number of columns per row (0 acts as 1).
// At the end of each row one result leaves on m_axis with that row's best
// area, the running best area and, in tlast, the end-of-matrix flag.
// A cell passes through ST_HGT, ST_RDTOP and ST_TOP; ST_TOP pops one stack
// entry at a time, as set by the single stack read port and the one
// multiply-compare unit that scores each popped bar. A row-ending cell
// then goes back to ST_RDTOP, pops every entry left on the stack and loads
// the result in ST_FIN. Pops are bounded by the pushes.
// The result sits in an output register; while m_axis stalls, the next
// cells are still taken until another row result is due.
// Reset and the final cell clear all heights, the stack and the running
// best; the column register keeps its value after the final cell.
// ----------------------------------------------------------------------------
module maximal_rectangle_binary_matrix (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [mrbm_pkg::CFG_W-1:0]       cfg_data_i,     // num_cols
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [mrbm_pkg::IN_DW-1:0]       s_axis_tdata,   // cell_req, zero fill
  input  logic                             s_axis_tlast,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [mrbm_pkg::OUT_DW-1:0]      m_axis_tdata,   // row_area, best_area, zero fill
  output logic                             m_axis_tlast
);

  mrbm_pkg::state_e state_q, state_d;

  logic [mrbm_pkg::CFG_W-1:0]  num_cols_q;
  logic [mrbm_pkg::CNTW-1:0]   ncols_q, ncols_d;
  logic [mrbm_pkg::CW-1:0]     col_pos_q, col_pos_d;
  logic [mrbm_pkg::CNTW-1:0]   count_q, count_d;
  logic [mrbm_pkg::AREA_W-1:0] row_best_q, row_best_d;
  logic [mrbm_pkg::AREA_W-1:0] best_q, best_d;
  logic [mrbm_pkg::HW-1:0]     h_q, h_d;
  logic                        cell_q, cell_d;
  logic                        last_q, last_d;
  logic                        flush_q, flush_d;
  logic [mrbm_pkg::MAX_COLS-1:0] vld_q, vld_d;

  logic                        out_valid_q, out_valid_d;
  logic [mrbm_pkg::AREA_W-1:0] out_row_q, out_row_d;
  logic [mrbm_pkg::AREA_W-1:0] out_best_q, out_best_d;
  logic                        out_final_q, out_final_d;

  logic                        h_we;
  logic [mrbm_pkg::HW-1:0]     h_rdata;
  logic [mrbm_pkg::HW-1:0]     h_prev;

  logic                        stk_we;
  logic [mrbm_pkg::CW-1:0]     stk_waddr;
  logic [mrbm_pkg::CW-1:0]     stk_raddr;
  mrbm_pkg::stk_entry_t        stk_wdata;
  mrbm_pkg::stk_entry_t        stk_top;

  logic                        in_acc;
  logic                        end_row;
  logic                        pop;
  logic                        emit;
  logic [mrbm_pkg::CNTW-1:0]   right;
  logic [mrbm_pkg::CNTW-1:0]   wid;
  logic [mrbm_pkg::PW-1:0]     prod;
  logic [mrbm_pkg::AREA_W-1:0] area;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == mrbm_pkg::ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_final_q;
  assign m_axis_tdata  = {(mrbm_pkg::OUT_DW - 2 * mrbm_pkg::AREA_W)'(0), out_best_q, out_row_q};

  assign end_row = last_q || ((mrbm_pkg::CNTW'(col_pos_q) + 1'b1) >= ncols_q);
  assign h_prev  = vld_q[col_pos_q] ? h_rdata : '0;

  assign pop   = (count_q != '0) && (flush_q || (stk_top.hgt >= h_q));
  assign right = flush_q ? mrbm_pkg::CNTW'(col_pos_q) + 1'b1 : mrbm_pkg::CNTW'(col_pos_q);
  assign wid   = right - mrbm_pkg::CNTW'(stk_top.left);
  assign prod  = mrbm_pkg::PW'(stk_top.hgt) * mrbm_pkg::PW'(wid);
  assign area  = (32'(prod) > 32'(mrbm_pkg::AREA_MAX)) ? mrbm_pkg::AREA_MAX
                                                        : mrbm_pkg::AREA_W'(prod);
  assign emit  = !out_valid_q || m_axis_tready;

  assign h_we      = (state_q == mrbm_pkg::ST_HGT);
  assign stk_raddr = mrbm_pkg::CW'(count_d - 1'b1);
  assign stk_waddr = mrbm_pkg::CW'(count_q);

  always_comb begin
    stk_wdata.idx  = col_pos_q;
    stk_wdata.left = (count_q != '0) ? stk_top.idx + 1'b1 : '0;
    stk_wdata.hgt  = h_q;
  end

  always_comb begin
    state_d     = state_q;
    ncols_d     = ncols_q;
    col_pos_d   = col_pos_q;
    count_d     = count_q;
    row_best_d  = row_best_q;
    best_d      = best_q;
    h_d         = h_q;
    cell_d      = cell_q;
    last_d      = last_q;
    flush_d     = flush_q;
    vld_d       = vld_q;
    stk_we      = 1'b0;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_row_d   = out_row_q;
    out_best_d  = out_best_q;
    out_final_d = out_final_q;

    unique case (state_q)
      mrbm_pkg::ST_IDLE: begin
        if (in_acc) begin
          cell_d  = s_axis_tdata[0];
          last_d  = s_axis_tlast;
          flush_d = 1'b0;
          if (num_cols_q == '0) begin
            ncols_d = mrbm_pkg::CNTW'(1);
          end else if (num_cols_q > mrbm_pkg::CFG_W'(mrbm_pkg::MAX_COLS)) begin
            ncols_d = mrbm_pkg::CNTW'(mrbm_pkg::MAX_COLS);
          end else begin
            ncols_d = mrbm_pkg::CNTW'(num_cols_q);
          end
          state_d = mrbm_pkg::ST_HGT;
        end
      end
      mrbm_pkg::ST_HGT: begin
        if (!cell_q) begin
          h_d = '0;
        end else if (h_prev < mrbm_pkg::HW'(mrbm_pkg::MAX_ROWS)) begin
          h_d = h_prev + 1'b1;
        end else begin
          h_d = h_prev;
        end
        vld_d[col_pos_q] = 1'b1;
        state_d = mrbm_pkg::ST_RDTOP;
      end
      mrbm_pkg::ST_RDTOP: begin
        state_d = mrbm_pkg::ST_TOP;
      end
      mrbm_pkg::ST_TOP: begin
        if (pop) begin
          count_d = count_q - 1'b1;
          if (area > row_best_q) begin
            row_best_d = area;
          end
        end else if (!flush_q) begin
          if (count_q < mrbm_pkg::CNTW'(mrbm_pkg::MAX_COLS)) begin
            stk_we  = 1'b1;
            count_d = count_q + 1'b1;
          end
          if (end_row) begin
            flush_d = 1'b1;
            state_d = mrbm_pkg::ST_RDTOP;
          end else begin
            col_pos_d = col_pos_q + 1'b1;
            state_d   = mrbm_pkg::ST_IDLE;
          end
        end else begin
          state_d = mrbm_pkg::ST_FIN;
        end
      end
      mrbm_pkg::ST_FIN: begin
        if (emit) begin
          out_valid_d = 1'b1;
          out_row_d   = row_best_q;
          out_best_d  = (row_best_q > best_q) ? row_best_q : best_q;
          out_final_d = last_q;
          best_d      = last_q ? '0 : out_best_d;
          row_best_d  = '0;
          count_d     = '0;
          col_pos_d   = '0;
          if (last_q) begin
            vld_d = '0;
          end
          state_d = mrbm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mrbm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mrbm_pkg::ST_IDLE;
      num_cols_q  <= mrbm_pkg::NUM_COLS_RST;
      col_pos_q   <= '0;
      count_q     <= '0;
      row_best_q  <= '0;
      best_q      <= '0;
      flush_q     <= 1'b0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        num_cols_q <= cfg_data_i;
      end
      col_pos_q   <= col_pos_d;
      count_q     <= count_d;
      row_best_q  <= row_best_d;
      best_q      <= best_d;
      flush_q     <= flush_d;
      vld_q       <= vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ncols_q     <= ncols_d;
    h_q         <= h_d;
    cell_q      <= cell_d;
    last_q      <= last_d;
    out_row_q   <= out_row_d;
    out_best_q  <= out_best_d;
    out_final_q <= out_final_d;
  end

  mrbm_ram #(
    .WIDTH (mrbm_pkg::HW),
    .DEPTH (mrbm_pkg::MAX_COLS)
  ) u_hgt_ram (
    .clk_i   (clk_i),
    .we_i    (h_we),
    .waddr_i (col_pos_q),
    .wdata_i (h_d),
    .raddr_i (col_pos_q),
    .rdata_o (h_rdata)
  );

  mrbm_ram #(
    .WIDTH ($bits(mrbm_pkg::stk_entry_t)),
    .DEPTH (mrbm_pkg::MAX_COLS)
  ) u_stk_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .raddr_i (stk_raddr),
    .rdata_o (stk_top)
  );

  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= mrbm_pkg::CNTW'(mrbm_pkg::MAX_COLS))
    else $error("stack count exceeds the column count");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready)
    else $error("new cell accepted while the previous one is in work");

  a_best_covers_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_best_q >= out_row_q))
    else $error("running best below the row area");

  a_final_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mrbm_pkg::ST_FIN && emit && last_q)
      |=> (best_q == '0 && vld_q == '0 && col_pos_q == '0))
    else $error("state not cleared after the final cell");

endmodule

### sv/mrbm_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mrbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
